@@ rtl/urm_pkg.sv @@
// Shared types and constants for the ultrasonic ranging median unit.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package urm_pkg;

    // Field and register widths
    localparam int W_TICK    = 18;
    localparam int W_TRIG    = 8;
    localparam int W_DVS     = 10;
    localparam int W_CM      = 19;
    localparam int W_MM      = 23;
    localparam int W_IDX     = 4;
    localparam int W_CFG_IDX = 3;

    // Iterative divider: one quotient bit per step
    localparam int DIV_STEPS = W_TICK;
    localparam int W_DCNT    = 5;

    localparam logic [W_TICK-1:0] TICK_MAX = '1;

    // Configuration register indexes
    localparam logic [W_CFG_IDX-1:0] REG_TRIG_LOW  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_TRIG_HIGH = 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_TPC       = 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_GAP       = 3'd4;

    // Configuration reset values
    localparam logic [W_TRIG-1:0] RST_TRIG_LOW  = 8'd2;
    localparam logic [W_TRIG-1:0] RST_TRIG_HIGH = 8'd10;
    localparam logic [W_TICK-1:0] RST_TIMEOUT   = 18'd60000;
    localparam logic [W_DVS-1:0]  RST_TPC       = 10'd58;
    localparam logic [W_TICK-1:0] RST_GAP       = 18'd50000;

    // Ranging phase per tick
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_WEND,
        PH_WRISE,
        PH_MEAS,
        PH_GAP
    } phase_t;

    // Word sequencer of the top level
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_FIN,
        SQ_MED,
        SQ_OUT
    } seq_state_t;

    // Median rank scan
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_ISSUE,
        MD_CAND,
        MD_SCAN
    } med_state_t;

endpackage

@@ rtl/urm_div.sv @@
// Iterative restoring divider, 18-bit dividend by 10-bit divisor.
// One quotient bit per cycle; uses urm_pkg widths.
`timescale 1ns / 1ps

module urm_div
    import urm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W_TICK-1:0] dividend,
    input  logic [W_DVS-1:0]  divisor,
    output logic              done,
    output logic [W_TICK-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [W_DCNT-1:0] cnt_reg, cnt_next;
    logic [W_TICK-1:0] quo_reg, quo_next;
    logic [W_DVS-1:0]  rem_reg, rem_next;
    logic [W_DVS-1:0]  dvs_reg, dvs_next;

    logic [W_DVS:0]    rem_sh;
    logic [W_DVS+1:0]  diff;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[W_TICK-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign fits   = ~diff[W_DVS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = W_DCNT'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? diff[W_DVS-1:0] : rem_sh[W_DVS-1:0];
            quo_next = {quo_reg[W_TICK-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == W_DCNT'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/urm_med.sv @@
// Reading store and median finder: rank scan with one shared comparator.
// Each candidate is ranked against all readings; uses urm_pkg types.
`timescale 1ns / 1ps

module urm_med
    import urm_pkg::*;
#(
    parameter int SAMPLES = 5,
    localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic signed [W_CM-1:0] wr_data,
    input  logic                   start,
    output logic                   done,
    output logic signed [W_CM-1:0] median
);

    logic signed [W_CM-1:0] mem [SAMPLES];

    med_state_t             st_reg, st_next;
    logic [AW-1:0]          c_reg, c_next;
    logic [AW-1:0]          j_reg, j_next;
    logic [AW-1:0]          rank_reg, rank_next;
    logic signed [W_CM-1:0] cand_reg, cand_next;
    logic signed [W_CM-1:0] rd_data_reg;
    logic signed [W_CM-1:0] median_reg, median_next;
    logic                   done_reg, done_next;

    logic [AW-1:0]          rd_addr;
    logic                   less;
    logic                   last_j;
    logic [AW-1:0]          rank_sum;
    logic                   hit;

    // equal values break ties by position so every rank is taken once
    assign less     = (rd_data_reg < cand_reg) || ((rd_data_reg == cand_reg) && (j_reg < c_reg));
    assign last_j   = (j_reg == AW'(SAMPLES - 1));
    assign rank_sum = rank_reg + AW'(less);
    assign hit      = (rank_sum == AW'(SAMPLES / 2));

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                    st_next = MD_ISSUE;
            end
            MD_ISSUE:
                st_next = MD_CAND;
            MD_CAND:
                st_next = MD_SCAN;
            MD_SCAN:
            begin
                if (last_j)
                    st_next = hit ? MD_IDLE : MD_CAND;
            end
            default:
                st_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        c_next      = c_reg;
        j_next      = j_reg;
        rank_next   = rank_reg;
        cand_next   = cand_reg;
        median_next = median_reg;
        done_next   = 1'b0;
        rd_addr     = c_reg;
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                    c_next = '0;
            end
            MD_ISSUE:
                rd_addr = c_reg;
            MD_CAND:
            begin
                // hold the candidate, start the scan at entry zero
                cand_next = rd_data_reg;
                j_next    = '0;
                rank_next = '0;
                rd_addr   = '0;
            end
            MD_SCAN:
            begin
                j_next    = j_reg + 1'b1;
                rank_next = rank_sum;
                rd_addr   = j_reg + 1'b1;
                if (last_j)
                begin
                    if (hit)
                    begin
                        median_next = cand_reg;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        c_next  = c_reg + 1'b1;
                        rd_addr = c_reg + 1'b1;
                    end
                end
            end
            default:
                rd_addr = c_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MD_IDLE;
            done_reg <= 1'b0;
            c_reg    <= '0;
            j_reg    <= '0;
            rank_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            c_reg    <= c_next;
            j_reg    <= j_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        median_reg <= median_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign done   = done_reg;
    assign median = median_reg;

endmodule

@@ rtl/ultrasonic_ranging_median_unit.sv @@
// Ultrasonic echo ranging with median-of-SAMPLES smoothing, one word per tick.
// Each tick word passes the sequencer states idle and out; a finished reading adds the
// iterative divider, and the burst end adds the rank scan.
// Throughput: one tick word at a time; the input stalls until the result is taken.
// Reset: asynchronous, active low; registers to defaults, idle; store undefined.
`timescale 1ns / 1ps

module ultrasonic_ranging_median_unit
    import urm_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [W_CFG_IDX-1:0]     cfg_index,
    input  logic [W_TICK-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     start_req,
    input  logic                     echo_level,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     trigger_level,
    output logic                     busy_res,
    output logic                     sample_valid,
    output logic signed [W_CM-1:0]   sample_cm,
    output logic                     median_valid,
    output logic signed [W_CM-1:0]   median_cm,
    output logic signed [W_MM-1:0]   median_mm
);

    localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    typedef struct packed {
        phase_t           phase;
        logic [W_IDX-1:0] idx;
        logic             med;
    } gap_end_t;

    function automatic phase_t low_entry(input logic [W_TRIG-1:0] lo,
                                         input logic [W_TRIG-1:0] hi);
        phase_t p;
        if (lo != '0)
            p = PH_TLOW;
        else if (hi != '0)
            p = PH_THIGH;
        else
            p = PH_WEND;
        return p;
    endfunction

    function automatic gap_end_t end_gap(input logic [W_IDX-1:0] idx,
                                         input logic [W_TRIG-1:0] lo,
                                         input logic [W_TRIG-1:0] hi);
        gap_end_t         g;
        logic [W_IDX-1:0] nxt;
        nxt   = idx + 1'b1;
        g.med = (nxt >= W_IDX'(SAMPLES));
        if (g.med)
        begin
            g.phase = PH_IDLE;
            g.idx   = '0;
        end
        else
        begin
            g.phase = low_entry(lo, hi);
            g.idx   = nxt;
        end
        return g;
    endfunction

    // configuration
    logic [W_TRIG-1:0]  cfg_tlow_reg, cfg_thigh_reg;
    logic [W_TICK-1:0]  cfg_timeout_reg, cfg_gap_reg;
    logic [W_DVS-1:0]   cfg_tpc_reg;

    // sequencer and ranging state
    seq_state_t         seq_reg, seq_next;
    phase_t             phase_reg, phase_next;
    logic [W_TICK-1:0]  ptimer_reg, ptimer_next;
    logic [W_TICK-1:0]  ltimer_reg, ltimer_next;
    logic [W_TICK-1:0]  width_reg, width_next;
    logic [W_IDX-1:0]   idx_reg, idx_next;
    logic [W_TICK-1:0]  finw_reg, finw_next;

    // result word
    logic                   smp_valid_reg, smp_valid_next;
    logic signed [W_CM-1:0] smp_cm_reg, smp_cm_next;
    logic                   med_valid_reg, med_valid_next;
    logic signed [W_CM-1:0] med_cm_reg, med_cm_next;
    logic signed [W_MM-1:0] med_mm_reg, med_mm_next;

    // per-tick step
    phase_t             t_phase;
    logic [W_TICK-1:0]  t_pt, t_lt, t_w, t_finw;
    logic [W_IDX-1:0]   t_idx;
    logic               t_fin, t_med, t_eg, listening;
    logic [W_TICK-1:0]  pt_inc, lt_inc;
    gap_end_t           tick_ge;

    // reading finish step
    logic signed [W_CM-1:0] r_val;
    gap_end_t           fin_ge;
    logic               gap_zero;

    logic               in_acc;
    logic               div_start, div_done;
    logic [W_DVS-1:0]   div_dvs;
    logic [W_TICK-1:0]  div_q;
    logic               med_start, med_done;
    logic signed [W_CM-1:0] med_q;
    logic               st_wr;
    logic [W_MM-1:0]    mm_ext;

    assign in_acc   = in_valid && (seq_reg == SQ_IDLE);
    assign pt_inc   = ptimer_reg + 1'b1;
    assign lt_inc   = (ltimer_reg != TICK_MAX) ? ltimer_reg + 1'b1 : ltimer_reg;
    assign gap_zero = (cfg_gap_reg == '0);
    assign div_dvs  = (cfg_tpc_reg == '0) ? W_DVS'(1) : cfg_tpc_reg;
    assign tick_ge  = end_gap(idx_reg, cfg_tlow_reg, cfg_thigh_reg);
    assign fin_ge   = end_gap(idx_reg, cfg_tlow_reg, cfg_thigh_reg);
    assign r_val    = (finw_reg == '0) ? '1 : $signed({1'b0, div_q});
    assign mm_ext   = {{(W_MM - W_CM){1'b0}}, med_q};

    // one microsecond tick of the ranging sequence
    always_comb
    begin
        t_phase   = phase_reg;
        t_pt      = ptimer_reg;
        t_lt      = ltimer_reg;
        t_w       = width_reg;
        t_idx     = idx_reg;
        t_fin     = 1'b0;
        t_finw    = '0;
        t_eg      = 1'b0;
        t_med     = 1'b0;
        listening = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    t_idx   = '0;
                    t_phase = low_entry(cfg_tlow_reg, cfg_thigh_reg);
                    t_pt    = '0;
                    t_lt    = '0;
                    t_w     = '0;
                end
            end
            PH_TLOW:
            begin
                t_pt = pt_inc;
                if (pt_inc >= W_TICK'(cfg_tlow_reg))
                begin
                    t_pt    = '0;
                    t_phase = (cfg_thigh_reg != '0) ? PH_THIGH : PH_WEND;
                    t_lt    = '0;
                    t_w     = '0;
                end
            end
            PH_THIGH:
            begin
                t_pt = pt_inc;
                if (pt_inc >= W_TICK'(cfg_thigh_reg))
                begin
                    t_phase = PH_WEND;
                    t_lt    = '0;
                    t_w     = '0;
                end
            end
            PH_WEND:
            begin
                listening = 1'b1;
                if (!echo_level)
                    t_phase = PH_WRISE;
            end
            PH_WRISE:
            begin
                listening = 1'b1;
                if (echo_level)
                begin
                    t_phase = PH_MEAS;
                    t_w     = W_TICK'(1);
                end
            end
            PH_MEAS:
            begin
                if (echo_level)
                begin
                    listening = 1'b1;
                    if (width_reg != TICK_MAX)
                        t_w = width_reg + 1'b1;
                end
                else
                begin
                    t_fin  = 1'b1;
                    t_finw = width_reg;
                end
            end
            PH_GAP:
            begin
                t_pt = pt_inc;
                if (pt_inc >= cfg_gap_reg)
                    t_eg = 1'b1;
            end
            default:
                t_phase = PH_IDLE;
        endcase
        if (listening)
        begin
            t_lt = lt_inc;
            // timeout ends the reading with zero width
            if (lt_inc >= cfg_timeout_reg)
            begin
                t_fin  = 1'b1;
                t_finw = '0;
            end
        end
        if (t_eg)
        begin
            t_phase = tick_ge.phase;
            t_idx   = tick_ge.idx;
            t_med   = tick_ge.med;
            t_pt    = '0;
            t_lt    = '0;
            t_w     = '0;
        end
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (in_acc)
                begin
                    if (t_fin)
                        seq_next = (t_finw != '0) ? SQ_DIV : SQ_FIN;
                    else if (t_med)
                        seq_next = SQ_MED;
                    else
                        seq_next = SQ_OUT;
                end
            end
            SQ_DIV:
            begin
                if (div_done)
                    seq_next = SQ_FIN;
            end
            SQ_FIN:
                seq_next = (gap_zero && fin_ge.med) ? SQ_MED : SQ_OUT;
            SQ_MED:
            begin
                if (med_done)
                    seq_next = SQ_OUT;
            end
            SQ_OUT:
            begin
                if (!out_stall)
                    seq_next = SQ_IDLE;
            end
            default:
                seq_next = SQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (seq_reg != SQ_IDLE);
        out_valid = (seq_reg == SQ_OUT);
        div_start = (seq_reg == SQ_IDLE) && in_acc && t_fin && (t_finw != '0);
        med_start = ((seq_reg == SQ_IDLE) && in_acc && !t_fin && t_med)
                 || ((seq_reg == SQ_FIN) && gap_zero && fin_ge.med);
        st_wr     = (seq_reg == SQ_FIN) && (idx_reg < W_IDX'(SAMPLES));
    end

    // datapath updates
    always_comb
    begin
        phase_next     = phase_reg;
        ptimer_next    = ptimer_reg;
        ltimer_next    = ltimer_reg;
        width_next     = width_reg;
        idx_next       = idx_reg;
        finw_next      = finw_reg;
        smp_valid_next = smp_valid_reg;
        smp_cm_next    = smp_cm_reg;
        med_valid_next = med_valid_reg;
        med_cm_next    = med_cm_reg;
        med_mm_next    = med_mm_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (in_acc)
                begin
                    phase_next     = t_phase;
                    ptimer_next    = t_pt;
                    ltimer_next    = t_lt;
                    width_next     = t_w;
                    idx_next       = t_idx;
                    finw_next      = t_finw;
                    smp_valid_next = 1'b0;
                    smp_cm_next    = '0;
                    med_valid_next = 1'b0;
                    med_cm_next    = '0;
                    med_mm_next    = '0;
                end
            end
            SQ_FIN:
            begin
                smp_valid_next = 1'b1;
                smp_cm_next    = r_val;
                phase_next     = PH_GAP;
                ptimer_next    = '0;
                if (gap_zero)
                begin
                    phase_next  = fin_ge.phase;
                    idx_next    = fin_ge.idx;
                    ltimer_next = '0;
                    width_next  = '0;
                end
            end
            SQ_MED:
            begin
                if (med_done)
                begin
                    med_valid_next = 1'b1;
                    med_cm_next    = med_q;
                    // times ten as shift-add; timeout stays -1
                    med_mm_next    = med_q[W_CM-1] ? '1
                                   : $signed((mm_ext << 3) + (mm_ext << 1));
                end
            end
            default:
                phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            phase_reg     <= PH_IDLE;
            ptimer_reg    <= '0;
            ltimer_reg    <= '0;
            width_reg     <= '0;
            idx_reg       <= '0;
            smp_valid_reg <= 1'b0;
            med_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            ptimer_reg    <= ptimer_next;
            ltimer_reg    <= ltimer_next;
            width_reg     <= width_next;
            idx_reg       <= idx_next;
            smp_valid_reg <= smp_valid_next;
            med_valid_reg <= med_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        finw_reg   <= finw_next;
        smp_cm_reg <= smp_cm_next;
        med_cm_reg <= med_cm_next;
        med_mm_reg <= med_mm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_tlow_reg    <= RST_TRIG_LOW;
            cfg_thigh_reg   <= RST_TRIG_HIGH;
            cfg_timeout_reg <= RST_TIMEOUT;
            cfg_tpc_reg     <= RST_TPC;
            cfg_gap_reg     <= RST_GAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIG_LOW:  cfg_tlow_reg    <= cfg_data[W_TRIG-1:0];
                REG_TRIG_HIGH: cfg_thigh_reg   <= cfg_data[W_TRIG-1:0];
                REG_TIMEOUT:   cfg_timeout_reg <= cfg_data;
                REG_TPC:       cfg_tpc_reg     <= cfg_data[W_DVS-1:0];
                REG_GAP:       cfg_gap_reg     <= cfg_data;
                default:       cfg_tlow_reg    <= cfg_tlow_reg;
            endcase
        end
    end

    urm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (t_finw),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    urm_med #(
        .SAMPLES (SAMPLES)
    ) u_med (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (r_val),
        .start   (med_start),
        .done    (med_done),
        .median  (med_q)
    );

    assign trigger_level = (phase_reg == PH_THIGH);
    assign busy_res      = (phase_reg != PH_IDLE);
    assign sample_valid  = smp_valid_reg;
    assign sample_cm     = smp_cm_reg;
    assign median_valid  = med_valid_reg;
    assign median_cm     = med_cm_reg;
    assign median_mm     = med_mm_reg;

endmodule
